/* hdl/rht_pkg.sv */
package rht_pkg;

  // widest slot index the block supports
  localparam int unsigned SLOT_IDX_W = 4;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  // result status codes
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_KEY    = 2'd1;
  localparam logic [1:0] STS_FULL   = 2'd2;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  // one stored route
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [7:0]  nh_if;
    logic [47:0] nh_mac;
    logic [7:0]  hops;
    logic [31:0] bcast;
    logic [31:0] stamp;
  } slot_t;

  // outcome of scanning one bucket row
  typedef struct packed {
    logic      hit;
    slot_idx_t hit_idx;
    logic      free;
    slot_idx_t free_idx;
  } scan_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_t;

endpackage

/* hdl/route_hash_table.sv */
// channel | dir | tvalid/tready | tdata                              | tuser
// in_     | in  | in_tvalid/rdy | dst_ip,if,mac,hops,bcast,stamp     | req_type
// out_    | out | out_tvalid/rdy| status,found,if,mac,hops,bcast,stmp | -
//
// one request at a time: the accept edge registers the bucket row; in the
// eval state all slots are compared, the row is written back and the result
// word is loaded once the result register is free, a read-modify-write on the
// single row memory. after reset a clearing pass zeroes every row; in_tready
// stays low until it ends. a stalled result holds the compare stage, while a
// waiting result alone does not stop the next request from being taken.
module route_hash_table
  import rht_pkg::*;
#(
  parameter int unsigned BUCKETS          = 10,
  parameter int unsigned SLOTS_PER_BUCKET = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] dst_ip, [39:32] nh_if, [87:40] next_hop_mac, [95:88] hops,
  // [127:96] bcast_id, [159:128] stamp
  input  logic [159:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [2] found, [10:3] out_if, [58:11] out_mac, [66:59] out_hops,
  // [98:67] out_bcast, [130:99] out_stamp, [135:131] zero
  output logic [135:0] out_tdata
);

  localparam int unsigned RW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

  // bucket of each last address byte, built at elaboration
  logic [RW-1:0] mod_tab [256];
  for (genvar i = 0; i < 256; i++) begin : g_mod
    assign mod_tab[i] = RW'(i % BUCKETS);
  end

  // state machine
  state_t state_r, state_nxt;
  logic   clr_last;
  logic   out_free;
  logic   in_fire;
  logic   eval_go;
  logic   clr_go;
  logic   out_valid_r;

  logic [RW-1:0] clr_cnt_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign clr_last = (clr_cnt_r == RW'(BUCKETS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_fire) state_nxt = ST_EVAL;
      ST_EVAL:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    eval_go   = 1'b0;
    clr_go    = 1'b0;
    case (state_r)
      ST_CLEAR: clr_go = 1'b1;
      ST_IDLE:  in_tready = 1'b1;
      ST_EVAL:  eval_go = out_free;
      default:  clr_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_go) begin
        clr_cnt_r <= clr_cnt_r + RW'(1);
      end
    end
  end

  // request capture
  logic [1:0]    req_r;
  slot_t         ins_r;
  logic [RW-1:0] row_addr_r;
  logic [RW-1:0] rd_addr;

  assign rd_addr = mod_tab[in_tdata[7:0]];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r        <= in_tuser;
      row_addr_r   <= rd_addr;
      ins_r.valid  <= 1'b1;
      ins_r.key    <= in_tdata[31:0];
      ins_r.nh_if  <= in_tdata[39:32];
      ins_r.nh_mac <= in_tdata[87:40];
      ins_r.hops   <= in_tdata[95:88];
      ins_r.bcast  <= in_tdata[127:96];
      ins_r.stamp  <= in_tdata[159:128];
    end
  end

  // bucket row memory
  slot_t         mem [BUCKETS][SLOTS_PER_BUCKET];
  slot_t         rd_row_r [SLOTS_PER_BUCKET];
  slot_t         wr_row [SLOTS_PER_BUCKET];
  logic          wr_en;
  logic [RW-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // slot compare
  scan_t scan;

  rht_bucket_scan #(
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) u_scan (
    .row  (rd_row_r),
    .key  (ins_r.key),
    .scan (scan)
  );

  // decision, row update and result
  logic [1:0] status_nxt;
  logic       found_nxt;
  slot_t      hit_slot;
  logic       modify;

  always_comb begin
    wr_row     = rd_row_r;
    modify     = 1'b0;
    status_nxt = STS_OK;
    found_nxt  = scan.hit;
    hit_slot   = '0;
    case (req_r)
      REQ_INSERT: begin
        if (scan.hit) begin
          status_nxt = STS_KEY;
        end else if (!scan.free) begin
          status_nxt = STS_FULL;
        end else begin
          modify = 1'b1;
          wr_row[scan.free_idx[SW-1:0]] = ins_r;
        end
      end
      REQ_DELETE: begin
        if (scan.hit) begin
          modify = 1'b1;
          wr_row[scan.hit_idx[SW-1:0]].valid = 1'b0;
        end else begin
          status_nxt = STS_KEY;
        end
      end
      default: begin
        // lookup, and the unused code behaves the same
        if (scan.hit) begin
          hit_slot = rd_row_r[scan.hit_idx[SW-1:0]];
        end else begin
          status_nxt = STS_KEY;
        end
      end
    endcase
    if (clr_go) begin
      for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
        wr_row[s] = '0;
      end
    end
  end

  assign wr_en   = clr_go || (eval_go && modify);
  assign wr_addr = clr_go ? clr_cnt_r : row_addr_r;

  // result word register
  logic [1:0]  status_r;
  logic        found_r;
  slot_t       res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eval_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_go) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      res_r    <= hit_slot;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.stamp, res_r.bcast, res_r.hops, res_r.nh_mac,
                       res_r.nh_if, found_r, status_r};

endmodule

/* hdl/rht_bucket_scan.sv */
module rht_bucket_scan
  import rht_pkg::*;
#(
  parameter int unsigned SLOTS_PER_BUCKET = 4
) (
  input  slot_t       row [SLOTS_PER_BUCKET],
  input  logic [31:0] key,
  output scan_t       scan
);

  // priority search: lowest matching slot and lowest free slot win
  always_comb begin
    scan = '0;
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      if (row[s].valid) begin
        if (row[s].key == key) begin
          scan.hit     = 1'b1;
          scan.hit_idx = SLOT_IDX_W'(s);
        end
      end else begin
        scan.free     = 1'b1;
        scan.free_idx = SLOT_IDX_W'(s);
      end
    end
  end

endmodule
